// ===== hw/rtl/kfca_pkg.sv =====
package kfca_pkg;

  // Data widths
  localparam int unsigned DW      = 32;
  localparam int unsigned FRAC    = 16;
  localparam int unsigned ACC_W   = 52;
  localparam int unsigned NUM_W   = DW + FRAC;
  localparam int unsigned DEN_W   = 49;
  localparam int unsigned REM_W   = DEN_W + 1;
  localparam int unsigned CNT_W   = 6;

  // Configuration registers
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned CFG_W   = 31;
  localparam int unsigned DT_W    = 17;
  localparam int unsigned NOISE_W = 31;
  localparam int unsigned THR_W   = 16;

  localparam logic [IDX_W-1:0] REG_STEP_TIME     = 2'd0;
  localparam logic [IDX_W-1:0] REG_PROCESS_NOISE = 2'd1;
  localparam logic [IDX_W-1:0] REG_MEASURE_NOISE = 2'd2;
  localparam logic [IDX_W-1:0] REG_SING_THRESH   = 2'd3;

  localparam logic [DT_W-1:0]    STEP_TIME_RST = 17'd164;
  localparam logic [NOISE_W-1:0] NOISE_RST     = 31'd6554;
  localparam logic [THR_W-1:0]   THRESH_RST    = 16'd0;

  // Operand address space: bit 6 clear is scratch memory, set is a register
  localparam int unsigned AW        = 7;
  localparam int unsigned MW        = 6;
  localparam int unsigned MEM_DEPTH = 64;
  typedef logic [AW-1:0] addr_t;

  localparam addr_t A_P    = 7'd0;
  localparam addr_t A_INV  = 7'd9;
  localparam addr_t A_S    = 7'd18;
  localparam addr_t A_ADJ  = 7'd27;
  localparam addr_t A_K    = 7'd36;
  localparam addr_t A_T    = 7'd45;
  localparam addr_t A_E    = 7'd54;
  localparam addr_t A_HALF = 7'd57;
  localparam addr_t A_ONE  = 7'd64;
  localparam addr_t A_DT   = 7'd65;
  localparam addr_t A_Q    = 7'd66;
  localparam addr_t A_R    = 7'd67;
  localparam addr_t A_Y    = 7'd68;
  localparam addr_t A_ZERO = 7'd71;
  localparam addr_t A_X    = 7'd72;

  // Covariance is set to identity and the saved inverse cleared by a sweep after reset
  localparam int unsigned INIT_LEN  = 18;
  localparam int unsigned INIT_W    = 5;
  localparam int unsigned DRAIN_LEN = 4;

  localparam logic [DW-1:0] ONE_Q   = 32'h0001_0000;
  localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(SAT_MAX);
  localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_HI - ACC_W'(1);
  localparam logic [NUM_W-1:0] Q_POS_LIM = (NUM_W'(1) << (DW-1)) - NUM_W'(1);
  localparam logic [NUM_W-1:0] Q_NEG_LIM = NUM_W'(1) << (DW-1);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_ISSUE, ST_DRAIN, ST_DIVW, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_HALF, OP_PX, OP_AP, OP_PP,
    OP_S, OP_ADJ, OP_DET, OP_DIV, OP_K, OP_E, OP_XU, OP_IK, OP_PT, OP_PC
  } op_t;

  typedef enum logic [1:0] {WM_SAT, WM_HALF, WM_DET, WM_DIV} wmode_t;

  typedef struct packed {
    addr_t a;
    addr_t b;
    logic  neg;
  } term_t;

  function automatic logic [3:0] elx(logic [1:0] r, logic [1:0] c);
    return 4'({r, 1'b0}) + 4'(r) + 4'(c);
  endfunction

  function automatic addr_t at(addr_t base, logic [3:0] n);
    return base + addr_t'(n);
  endfunction

  // Transition matrix A, row major
  function automatic addr_t amat(logic [1:0] i, logic [1:0] j);
    addr_t a;
    case ({i, j})
      4'b0000, 4'b0101, 4'b1010: a = A_ONE;
      4'b0001, 4'b0110:          a = A_DT;
      4'b0010:                   a = A_HALF;
      default:                   a = A_ZERO;
    endcase
    return a;
  endfunction

  // Cofactor operands: adj = s[a]*s[b] - s[c]*s[d]
  function automatic logic [3:0] cof_idx(logic [3:0] el, logic [1:0] m);
    logic [15:0] v;
    logic [3:0]  r;
    case (el)
      4'd0:    v = {4'd4, 4'd8, 4'd5, 4'd7};
      4'd1:    v = {4'd2, 4'd7, 4'd1, 4'd8};
      4'd2:    v = {4'd1, 4'd5, 4'd2, 4'd4};
      4'd3:    v = {4'd5, 4'd6, 4'd3, 4'd8};
      4'd4:    v = {4'd0, 4'd8, 4'd2, 4'd6};
      4'd5:    v = {4'd2, 4'd3, 4'd0, 4'd5};
      4'd6:    v = {4'd3, 4'd7, 4'd4, 4'd6};
      4'd7:    v = {4'd1, 4'd6, 4'd0, 4'd7};
      4'd8:    v = {4'd0, 4'd4, 4'd1, 4'd3};
      default: v = '0;
    endcase
    case (m)
      2'd0:    r = v[15:12];
      2'd1:    r = v[11:8];
      2'd2:    r = v[7:4];
      default: r = v[3:0];
    endcase
    return r;
  endfunction

  function automatic logic [1:0] op_last_row(op_t op);
    return (op == OP_HALF || op == OP_DET) ? 2'd0 : 2'd2;
  endfunction

  function automatic logic [1:0] op_last_col(op_t op);
    logic [1:0] c;
    case (op)
      OP_HALF, OP_DET, OP_PX, OP_E, OP_XU: c = 2'd0;
      default:                             c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] op_last_term(op_t op);
    logic [1:0] t;
    case (op)
      OP_HALF, OP_DIV, OP_PC:      t = 2'd0;
      OP_S, OP_ADJ, OP_E, OP_IK:   t = 2'd1;
      OP_PP, OP_XU:                t = 2'd3;
      default:                     t = 2'd2;
    endcase
    return t;
  endfunction

  function automatic wmode_t op_mode(op_t op);
    wmode_t w;
    case (op)
      OP_HALF: w = WM_HALF;
      OP_DET:  w = WM_DET;
      OP_DIV:  w = WM_DIV;
      default: w = WM_SAT;
    endcase
    return w;
  endfunction

  function automatic addr_t op_dest(op_t op, logic [1:0] ri, logic [1:0] cj);
    logic [3:0] el;
    addr_t      d;
    el = elx(ri, cj);
    case (op)
      OP_HALF:       d = A_HALF;
      OP_PX, OP_XU:  d = at(A_X, 4'(ri));
      OP_AP, OP_PT:  d = at(A_T, el);
      OP_PP, OP_PC:  d = at(A_P, el);
      OP_S, OP_IK:   d = at(A_S, el);
      OP_ADJ:        d = at(A_ADJ, el);
      OP_DIV:        d = at(A_INV, el);
      OP_K:          d = at(A_K, el);
      OP_E:          d = at(A_E, 4'(ri));
      default:       d = A_ZERO;
    endcase
    return d;
  endfunction

  // One product term of an element: result = sum of +/- mulq(a, b)
  function automatic term_t op_term(op_t op, logic [1:0] ri, logic [1:0] cj,
                                    logic [1:0] k);
    term_t      t;
    logic [3:0] el;
    logic [3:0] ik;
    logic [3:0] kj;
    logic [1:0] km;
    logic       diag;
    el   = elx(ri, cj);
    ik   = elx(ri, k);
    kj   = elx(k, cj);
    km   = k - 2'd1;
    diag = (ri == cj);
    t    = '{a: A_ZERO, b: A_ZERO, neg: 1'b0};
    case (op)
      OP_HALF: begin
        t.a = A_DT;
        t.b = A_DT;
      end
      OP_PX: begin
        t.a = amat(ri, k);
        t.b = at(A_X, 4'(k));
      end
      OP_AP: begin
        t.a = amat(ri, k);
        t.b = at(A_P, kj);
      end
      OP_PP: begin
        if (k == 2'd3) begin
          if (diag) begin
            t.a = A_Q;
            t.b = A_ONE;
          end
        end else begin
          t.a = at(A_T, ik);
          t.b = amat(cj, k);
        end
      end
      OP_S: begin
        if (k == 2'd0) begin
          t.a = at(A_P, el);
          t.b = A_ONE;
        end else if (diag) begin
          t.a = A_R;
          t.b = A_ONE;
        end
      end
      OP_ADJ: begin
        t.a   = at(A_S, cof_idx(el, {k[0], 1'b0}));
        t.b   = at(A_S, cof_idx(el, {k[0], 1'b1}));
        t.neg = k[0];
      end
      OP_DET: begin
        t.a = at(A_S, 4'(k));
        t.b = at(A_ADJ, elx(k, 2'd0));
      end
      OP_DIV: begin
        t.a = at(A_ADJ, el);
        t.b = A_ONE;
      end
      OP_K: begin
        t.a = at(A_P, ik);
        t.b = at(A_INV, kj);
      end
      OP_E: begin
        t.a   = (k == 2'd0) ? at(A_Y, 4'(ri)) : at(A_X, 4'(ri));
        t.b   = A_ONE;
        t.neg = (k != 2'd0);
      end
      OP_XU: begin
        if (k == 2'd0) begin
          t.a = at(A_X, 4'(ri));
          t.b = A_ONE;
        end else begin
          t.a = at(A_K, elx(ri, km));
          t.b = at(A_E, 4'(km));
        end
      end
      OP_IK: begin
        if (k == 2'd0) begin
          if (diag) begin
            t.a = A_ONE;
            t.b = A_ONE;
          end
        end else begin
          t.a   = at(A_K, el);
          t.b   = A_ONE;
          t.neg = 1'b1;
        end
      end
      OP_PT: begin
        t.a = at(A_S, ik);
        t.b = at(A_P, kj);
      end
      OP_PC: begin
        t.a = at(A_T, el);
        t.b = A_ONE;
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic op_t op_after(op_t op, logic singular);
    op_t n;
    case (op)
      OP_HALF: n = OP_PX;
      OP_PX:   n = OP_AP;
      OP_AP:   n = OP_PP;
      OP_S:    n = OP_ADJ;
      OP_ADJ:  n = OP_DET;
      OP_DET:  n = singular ? OP_K : OP_DIV;
      OP_DIV:  n = OP_K;
      OP_K:    n = OP_E;
      OP_E:    n = OP_XU;
      OP_XU:   n = OP_IK;
      OP_IK:   n = OP_PT;
      OP_PT:   n = OP_PC;
      default: n = OP_HALF;
    endcase
    return n;
  endfunction

  function automatic logic [DW-1:0] sat_acc(logic signed [ACC_W-1:0] v);
    logic [DW-1:0] r;
    if (v > ACC_HI) r = SAT_MAX;
    else if (v < ACC_LO) r = SAT_MIN;
    else r = v[DW-1:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/kfca_if.sv =====
interface kfca_item_if;
  import kfca_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic signed [DW-1:0] meas_position;
  logic signed [DW-1:0] meas_velocity;
  logic signed [DW-1:0] meas_accel;

  modport source (output valid, cmd, meas_position, meas_velocity, meas_accel,
                  input ready);
  modport sink (input valid, cmd, meas_position, meas_velocity, meas_accel,
                output ready);
endinterface

interface kfca_result_if;
  import kfca_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] est_position;
  logic signed [DW-1:0] est_velocity;
  logic signed [DW-1:0] est_accel;
  logic                 used_last_inverse;

  modport source (output valid, est_position, est_velocity, est_accel,
                  used_last_inverse, input ready);
  modport sink (input valid, est_position, est_velocity, est_accel,
                used_last_inverse, output ready);
endinterface

// ===== hw/rtl/kalman_filter_3state_const_accel_top.sv =====
// Three-state (position, velocity, acceleration) Kalman filter, Q16.16.
// Channel item (valid/ready) carries one request: cmd 0 predicts, cmd 1
// updates with the three measured values. Channel result returns the state
// estimate after every request, plus a flag set when an update found the
// innovation matrix singular and reused the last good inverse.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
// it only while no request is in flight.
// All arithmetic runs through one 32x32 multiply-accumulate unit driven by
// a small sequencer, plus a one-bit-per-cycle divider for the inverse.
// Each matrix element is issued one product term at a time and then drained
// from the multiply pipeline. An update whose matrix is not singular also
// runs the nine divisions for the inverse, and these take the bulk of its
// time.
// Item ready is high only when the sequencer is idle; it drops for the whole
// computation. The result sits in an output register; a stalled receiver
// holds only the finished result, and a next request can already be taken.
// After reset the block sweeps the covariance to identity and clears the
// saved inverse before it accepts the first request.
module kalman_filter_3state_const_accel_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [kfca_pkg::IDX_W-1:0]  cfg_index,
  input  logic [kfca_pkg::CFG_W-1:0]  cfg_data,
  kfca_item_if.sink                   item,
  kfca_result_if.source               result
);
  import kfca_pkg::*;

  // Configuration
  logic [DT_W-1:0]    step_time;
  logic [NOISE_W-1:0] process_noise;
  logic [NOISE_W-1:0] measure_noise;
  logic [THR_W-1:0]   singular_threshold;

  // Sequencer
  state_t         state, state_next;
  op_t            op, op_next;
  logic [1:0]     ri, ri_next;
  logic [1:0]     cj, cj_next;
  logic [1:0]     k, k_next;
  logic [1:0]     dcnt, dcnt_next;
  logic [INIT_W-1:0] icnt, icnt_next;
  logic           cmd_q;
  logic           singular_q;
  logic           accept;
  logic           issue;
  logic           out_load;
  logic           step_done;
  term_t          term;

  // Datapath
  logic [DW-1:0]        mem [MEM_DEPTH];
  logic signed [DW-1:0] x_reg [3];
  logic signed [DW-1:0] y_reg [3];
  logic signed [DW-1:0] mem_a, mem_b, spc_a, spc_b, opa, opb;
  logic                 sel_a, sel_b;
  logic signed [63:0]   prod, prod_shr;
  logic signed [ACC_W-1:0] prod_sh, acc, det_reg;
  logic [ACC_W-1:0]     det_mag, adj_mag;
  logic                 singular;
  logic                 s1_v, s1_first, s1_last, s1_neg;
  logic                 s2_v, s2_first, s2_last, s2_neg;
  addr_t                s1_dest, s2_dest, w_dest;
  wmode_t               s1_mode, s2_mode, w_mode;
  logic                 wr_pend;

  // Write port
  logic          wen;
  addr_t         wa;
  logic [DW-1:0] wd;
  logic [1:0]    xi;

  // Divider
  logic                 div_start, div_busy, div_fin, div_neg, div_ge;
  logic [CNT_W-1:0]     div_cnt;
  logic [NUM_W-1:0]     div_num, div_quo;
  logic [REM_W-1:0]     div_rem, rem_sh;
  addr_t                div_dest;
  logic [DW-1:0]        div_res;

  // Output register
  logic                 out_valid;
  logic signed [DW-1:0] out_pos, out_vel, out_acc;
  logic                 out_flag;

  assign accept = item.valid && item.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time          <= STEP_TIME_RST;
      process_noise      <= NOISE_RST;
      measure_noise      <= NOISE_RST;
      singular_threshold <= THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_TIME:     step_time          <= cfg_data[DT_W-1:0];
        REG_PROCESS_NOISE: process_noise      <= cfg_data[NOISE_W-1:0];
        REG_MEASURE_NOISE: measure_noise      <= cfg_data[NOISE_W-1:0];
        REG_SING_THRESH:   singular_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      op    <= OP_HALF;
      ri    <= '0;
      cj    <= '0;
      k     <= '0;
      dcnt  <= '0;
      icnt  <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      ri    <= ri_next;
      cj    <= cj_next;
      k     <= k_next;
      dcnt  <= dcnt_next;
      icnt  <= icnt_next;
    end
  end

  // Next state: walk ops, elements and terms
  always_comb begin
    state_next = state;
    op_next    = op;
    ri_next    = ri;
    cj_next    = cj;
    k_next     = k;
    dcnt_next  = dcnt;
    icnt_next  = icnt;
    step_done  = 1'b0;
    case (state)
      ST_INIT: begin
        icnt_next = icnt + INIT_W'(1);
        if (icnt == INIT_W'(INIT_LEN - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_ISSUE;
          op_next    = item.cmd ? OP_S : OP_HALF;
          ri_next    = '0;
          cj_next    = '0;
          k_next     = '0;
        end
      end
      ST_ISSUE: begin
        if (k == op_last_term(op)) begin
          state_next = ST_DRAIN;
          dcnt_next  = '0;
        end else begin
          k_next = k + 2'd1;
        end
      end
      ST_DRAIN: begin
        dcnt_next = dcnt + 2'd1;
        if (dcnt == 2'(DRAIN_LEN - 1)) begin
          if (op == OP_DIV) state_next = ST_DIVW;
          else step_done = 1'b1;
        end
      end
      ST_DIVW: begin
        if (div_fin) step_done = 1'b1;
      end
      ST_DONE: begin
        if (!out_valid || result.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    // Advance to the next element or op
    if (step_done) begin
      k_next     = '0;
      state_next = ST_ISSUE;
      if (cj != op_last_col(op)) begin
        cj_next = cj + 2'd1;
      end else if (ri != op_last_row(op)) begin
        cj_next = '0;
        ri_next = ri + 2'd1;
      end else begin
        cj_next = '0;
        ri_next = '0;
        if (op == OP_PP || op == OP_PC) state_next = ST_DONE;
        else op_next = op_after(op, singular);
      end
    end
  end

  // Sequencer outputs
  always_comb begin
    item.ready = (state == ST_IDLE);
    issue      = (state == ST_ISSUE);
    out_load   = (state == ST_DONE) && (!out_valid || result.ready);
    term       = op_term(op, ri, cj, k);
  end

  // Capture request payload and the singular decision
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= item.cmd;
      y_reg[0] <= item.meas_position;
      y_reg[1] <= item.meas_velocity;
      y_reg[2] <= item.meas_accel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      singular_q <= 1'b0;
    end else if (accept) begin
      singular_q <= 1'b0;
    end else if (state == ST_DRAIN && dcnt == 2'(DRAIN_LEN - 1) && op == OP_DET) begin
      singular_q <= singular;
    end
  end

  // Register-space operand values
  function automatic logic [DW-1:0] spec_val(addr_t a);
    logic [DW-1:0] v;
    case (a)
      A_ONE:            v = ONE_Q;
      A_DT:             v = DW'(step_time);
      A_Q:              v = DW'(process_noise);
      A_R:              v = DW'(measure_noise);
      A_Y:              v = y_reg[0];
      A_Y + addr_t'(1): v = y_reg[1];
      A_Y + addr_t'(2): v = y_reg[2];
      A_X:              v = x_reg[0];
      A_X + addr_t'(1): v = x_reg[1];
      A_X + addr_t'(2): v = x_reg[2];
      default:          v = '0;
    endcase
    return v;
  endfunction

  // Scratch memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wen && !wa[AW-1]) mem[wa[MW-1:0]] <= wd;
    mem_a <= mem[term.a[MW-1:0]];
    mem_b <= mem[term.b[MW-1:0]];
    spc_a <= spec_val(term.a);
    spc_b <= spec_val(term.b);
    sel_a <= term.a[AW-1];
    sel_b <= term.b[AW-1];
  end

  assign opa = sel_a ? spc_a : mem_a;
  assign opb = sel_b ? spc_b : mem_b;

  // MAC pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      wr_pend <= 1'b0;
    end else begin
      s1_v    <= issue;
      s2_v    <= s1_v;
      wr_pend <= s2_v && s2_last;
    end
  end

  // MAC pipeline payload: read, multiply, accumulate
  always_ff @(posedge clk) begin
    s1_first <= (k == 2'd0);
    s1_last  <= (k == op_last_term(op));
    s1_neg   <= term.neg;
    s1_dest  <= op_dest(op, ri, cj);
    s1_mode  <= op_mode(op);
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_neg   <= s1_neg;
    s2_dest  <= s1_dest;
    s2_mode  <= s1_mode;
    prod     <= opa * opb;
    if (s2_v) acc <= (s2_first ? ACC_W'(0) : acc) + (s2_neg ? -prod_sh : prod_sh);
    w_dest   <= s2_dest;
    w_mode   <= s2_mode;
  end

  assign prod_shr = prod >>> FRAC;
  assign prod_sh  = prod_shr[ACC_W-1:0];

  // Determinant and singular test
  always_ff @(posedge clk) begin
    if (wr_pend && w_mode == WM_DET) det_reg <= acc;
  end

  assign det_mag  = det_reg[ACC_W-1] ? ACC_W'(-det_reg) : ACC_W'(det_reg);
  assign adj_mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign singular = (det_mag <= ACC_W'(singular_threshold));

  // Write port: reset sweep, divider result or MAC result
  always_comb begin
    wen = 1'b0;
    wa  = A_ZERO;
    wd  = '0;
    if (state == ST_INIT) begin
      wen = 1'b1;
      wa  = addr_t'(icnt);
      wd  = (icnt == INIT_W'(0) || icnt == INIT_W'(4) || icnt == INIT_W'(8)) ?
            ONE_Q : '0;
    end else if (div_fin) begin
      wen = 1'b1;
      wa  = div_dest;
      wd  = div_res;
    end else if (wr_pend && (w_mode == WM_SAT || w_mode == WM_HALF)) begin
      wen = 1'b1;
      wa  = w_dest;
      wd  = (w_mode == WM_HALF) ? sat_acc(acc >>> 1) : sat_acc(acc);
    end
  end

  assign xi = 2'(wa - A_X);

  // State estimate lives in registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_reg <= '{default: '0};
    end else if (wen && wa[AW-1]) begin
      x_reg[xi] <= wd;
    end
  end

  // Restoring divider: |adj| * 2^16 / |det|, one quotient bit per cycle
  assign div_start = wr_pend && (w_mode == WM_DIV);
  assign rem_sh    = {div_rem[REM_W-2:0], div_num[NUM_W-1]};
  assign div_ge    = (rem_sh >= REM_W'(det_mag[DEN_W-1:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_fin  <= 1'b0;
      div_cnt  <= '0;
    end else begin
      div_fin <= !div_start && div_busy && (div_cnt == '0);
      if (div_start) begin
        div_busy <= 1'b1;
        div_cnt  <= CNT_W'(NUM_W - 1);
      end else if (div_busy) begin
        div_cnt <= div_cnt - CNT_W'(1);
        if (div_cnt == '0) div_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_num  <= {adj_mag[DW-1:0], FRAC'(0)};
      div_rem  <= '0;
      div_quo  <= '0;
      div_neg  <= acc[ACC_W-1] ^ det_reg[ACC_W-1];
      div_dest <= w_dest;
    end else if (div_busy) begin
      div_num <= div_num << 1;
      div_rem <= div_ge ? rem_sh - REM_W'(det_mag[DEN_W-1:0]) : rem_sh;
      div_quo <= {div_quo[NUM_W-2:0], div_ge};
    end
  end

  // Sign and saturate the quotient
  always_comb begin
    if (!div_neg) begin
      div_res = (div_quo > Q_POS_LIM) ? SAT_MAX : div_quo[DW-1:0];
    end else begin
      div_res = (div_quo > Q_NEG_LIM) ? SAT_MIN : DW'(NUM_W'(0) - div_quo);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos  <= x_reg[0];
      out_vel  <= x_reg[1];
      out_acc  <= x_reg[2];
      out_flag <= cmd_q && singular_q;
    end
  end

  assign result.valid             = out_valid;
  assign result.est_position      = out_pos;
  assign result.est_velocity      = out_vel;
  assign result.est_accel         = out_acc;
  assign result.used_last_inverse = out_flag;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !item.ready)
    else $error("item ready stayed high after a request was taken");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (!div_busy && !div_fin))
    else $error("divider started while still busy");

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(div_fin && wr_pend))
    else $error("divider and MAC wrote in the same cycle");

  a_div_fin_waited: assert property (@(posedge clk) disable iff (rst)
    div_fin |-> (state == ST_DIVW))
    else $error("divider finished while sequencer was not waiting");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the done state");

endmodule
